>>> hw/rtl/bvpo_pkg.sv
`timescale 1ns / 1ps
package bvpo_pkg;

   // Geometry and register widths
   localparam int MAX_VERTICES_DEF = 16;
   localparam int COORD_W          = 16;
   localparam int INDEX_W          = 4;
   localparam int CNT_REG_W        = 5;
   localparam int HEIGHT_W         = 15;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_Z       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRISM_HEIGHT = 2'd2;

   localparam logic [CNT_REG_W-1:0]      COUNT_RESET  = 5'd4;
   localparam logic signed [COORD_W-1:0] BASE_Z_RESET = 16'sd0;
   localparam logic [HEIGHT_W-1:0]       HEIGHT_RESET = 15'd128;

   // Request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TEST  = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic start;    // latch box, clear parity, rewind vertex address
      logic write;    // store one vertex
      logic issue;    // read next vertex
      logic close;    // push the closing edge (last vertex back to first)
      logic deliver;  // load the result register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic zok;      // z spans overlap
      logic empty;    // no edges to walk
      logic last;     // current read address is the last vertex
      logic busy;     // edge pipeline holds work
   } dp_status_type;

endpackage

>>> hw/rtl/bvpo_if.sv
`timescale 1ns / 1ps
interface bvpo_req_if;
   import bvpo_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [INDEX_W-1:0]        vertex_index;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic signed [COORD_W-1:0] box_min_x;
   logic signed [COORD_W-1:0] box_min_y;
   logic signed [COORD_W-1:0] box_min_z;
   logic signed [COORD_W-1:0] box_max_x;
   logic signed [COORD_W-1:0] box_max_y;
   logic signed [COORD_W-1:0] box_max_z;

   modport source (
      output valid, func, vertex_index, vertex_x, vertex_y,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      input  ready
   );
   modport sink (
      input  valid, func, vertex_index, vertex_x, vertex_y,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      output ready
   );
   modport monitor (
      input valid, ready, func, vertex_index, vertex_x, vertex_y,
            box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   );
endinterface

interface bvpo_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
   modport monitor (input valid, ready, hit);
endinterface

>>> hw/rtl/bvpo_ram.sv
`timescale 1ns / 1ps
module bvpo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule

>>> hw/rtl/bvpo_ctrl.sv
`timescale 1ns / 1ps
module bvpo_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bvpo_pkg::ctrl_cmd_type  cmd,
   input  bvpo_pkg::dp_status_type status
);
   import bvpo_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_CLOSE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.start   = accept && (req_func == FUNC_TEST);
      cmd.write   = accept && (req_func == FUNC_WRITE);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // skip the edge walk on a z miss or an empty polygon
            if (!status.zok || status.empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.issue = 1'b1;
            if (status.last) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

>>> hw/rtl/bvpo_dp.sv
`timescale 1ns / 1ps
module bvpo_dp #(
   parameter int MAX_VERTICES = bvpo_pkg::MAX_VERTICES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bvpo_pkg::ctrl_cmd_type             cmd,
   output bvpo_pkg::dp_status_type            status,
   input  logic [bvpo_pkg::INDEX_W-1:0]       vertex_index,
   input  logic signed [bvpo_pkg::COORD_W-1:0] vertex_x,
   input  logic signed [bvpo_pkg::COORD_W-1:0] vertex_y,
   input  logic signed [bvpo_pkg::COORD_W-1:0] box_min_x,
   input  logic signed [bvpo_pkg::COORD_W-1:0] box_min_y,
   input  logic signed [bvpo_pkg::COORD_W-1:0] box_min_z,
   input  logic signed [bvpo_pkg::COORD_W-1:0] box_max_x,
   input  logic signed [bvpo_pkg::COORD_W-1:0] box_max_y,
   input  logic signed [bvpo_pkg::COORD_W-1:0] box_max_z,
   input  logic                               csr_we,
   input  logic [bvpo_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bvpo_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                               rsp_hit
);
   import bvpo_pkg::*;

   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int RAM_W  = 2 * COORD_W;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int Z_W    = COORD_W + 2;

   function automatic logic signed [DIFF_W-1:0] sx_diff(input logic signed [COORD_W-1:0] v);
      return $signed({v[COORD_W-1], v});
   endfunction

   function automatic logic signed [Z_W-1:0] sx_z(input logic signed [COORD_W-1:0] v);
      return $signed({{2{v[COORD_W-1]}}, v});
   endfunction

   // ---------------- configuration registers ----------------
   logic [CNT_REG_W-1:0]      count_ff;
   logic signed [COORD_W-1:0] base_z_ff;
   logic [HEIGHT_W-1:0]       height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_RESET;
         base_z_ff <= BASE_Z_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT: count_ff  <= csr_wdata[CNT_REG_W-1:0];
            CSR_BASE_Z:       base_z_ff <= $signed(csr_wdata);
            CSR_PRISM_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // saturate the vertex count to the table depth
   logic [CNT_W-1:0] count_sat;
   assign count_sat = (32'(count_ff) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                          : CNT_W'(count_ff);

   // ---------------- z overlap and box capture ----------------
   logic signed [Z_W-1:0]     roof, z_hi;
   logic signed [COORD_W-1:0] z_lo;
   logic                      zok_in;

   assign roof   = $signed(18'(sx_z(base_z_ff)) + {3'b000, height_ff});
   assign z_lo   = (box_min_z > base_z_ff) ? box_min_z : base_z_ff;
   assign z_hi   = (sx_z(box_max_z) < roof) ? sx_z(box_max_z) : roof;
   assign zok_in = (sx_z(z_lo) <= z_hi);

   logic signed [COORD_W-1:0] mnx_ff, mny_ff, mxx_ff, mxy_ff;
   logic                      zok_ff;
   logic [ADDR_W-1:0]         addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mnx_ff <= box_min_x;
         mny_ff <= box_min_y;
         mxx_ff <= box_max_x;
         mxy_ff <= box_max_y;
         zok_ff <= zok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else if (cmd.start) begin
         addr_ff <= '0;
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + 1'b1;
      end
   end

   // ---------------- vertex memory ----------------
   logic             ram_we;
   logic [RAM_W-1:0] ram_rdata;

   assign ram_we = cmd.write && (32'(vertex_index) < 32'(MAX_VERTICES));

   bvpo_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(vertex_index)),
      .wdata ({vertex_x, vertex_y}),
      .re    (cmd.issue),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   // ---------------- edge pipeline ----------------
   logic rd_v_ff, rd_first_ff, close_ff, e_v_ff, d_v_ff, m_v_ff;

   logic signed [COORD_W-1:0] rx, ry;
   logic signed [COORD_W-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;

   assign rx = $signed(ram_rdata[RAM_W-1:COORD_W]);
   assign ry = $signed(ram_rdata[COORD_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff     <= 1'b0;
         rd_first_ff <= 1'b0;
         close_ff    <= 1'b0;
         e_v_ff      <= 1'b0;
         d_v_ff      <= 1'b0;
         m_v_ff      <= 1'b0;
      end else begin
         rd_v_ff     <= cmd.issue;
         rd_first_ff <= cmd.issue && (addr_ff == '0);
         close_ff    <= cmd.close;
         e_v_ff      <= (rd_v_ff && !rd_first_ff) || close_ff;
         d_v_ff      <= e_v_ff;
         m_v_ff      <= d_v_ff;
      end
   end

   // form edges from consecutive vertices; the closing edge wraps to the first
   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         prev_x_ff <= rx;
         prev_y_ff <= ry;
         if (rd_first_ff) begin
            first_x_ff <= rx;
            first_y_ff <= ry;
         end else begin
            x1_ff <= prev_x_ff;
            y1_ff <= prev_y_ff;
            x2_ff <= rx;
            y2_ff <= ry;
         end
      end else if (close_ff) begin
         x1_ff <= prev_x_ff;
         y1_ff <= prev_y_ff;
         x2_ff <= first_x_ff;
         y2_ff <= first_y_ff;
      end
   end

   // corners: 0 (min x, min y), 1 (max x, max y), 2 (min x, max y), 3 (max x, min y)
   logic signed [COORD_W-1:0] px [4];
   logic signed [COORD_W-1:0] py [4];

   assign px[0] = mnx_ff;
   assign px[1] = mxx_ff;
   assign px[2] = mnx_ff;
   assign px[3] = mxx_ff;
   assign py[0] = mny_ff;
   assign py[1] = mxy_ff;
   assign py[2] = mxy_ff;
   assign py[3] = mny_ff;

   // difference stage
   logic signed [COORD_W-1:0] ylo, yhi, xhi;
   logic [3:0]                cond_in;
   logic signed [DIFF_W-1:0]  d_ff, ex_ff, dxa_ff, dxb_ff, dya_ff, dyb_ff;
   logic [3:0]                cond_d_ff;
   logic                      vert_d_ff, dpos_d_ff;

   assign ylo = (y1_ff < y2_ff) ? y1_ff : y2_ff;
   assign yhi = (y1_ff < y2_ff) ? y2_ff : y1_ff;
   assign xhi = (x1_ff < x2_ff) ? x2_ff : x1_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cond_in[k] = (y1_ff != y2_ff) && (py[k] > ylo) && (py[k] <= yhi) && (px[k] <= xhi);
      end
   end

   always_ff @(posedge clock) begin
      d_ff      <= sx_diff(y2_ff) - sx_diff(y1_ff);
      ex_ff     <= sx_diff(x2_ff) - sx_diff(x1_ff);
      dxa_ff    <= sx_diff(mnx_ff) - sx_diff(x1_ff);
      dxb_ff    <= sx_diff(mxx_ff) - sx_diff(x1_ff);
      dya_ff    <= sx_diff(mny_ff) - sx_diff(y1_ff);
      dyb_ff    <= sx_diff(mxy_ff) - sx_diff(y1_ff);
      cond_d_ff <= cond_in;
      vert_d_ff <= (x1_ff == x2_ff);
      dpos_d_ff <= (y2_ff > y1_ff);
   end

   // product stage
   logic signed [PROD_W-1:0] lhs_a_ff, lhs_b_ff, rhs_a_ff, rhs_b_ff;
   logic [3:0]               cond_m_ff;
   logic                     vert_m_ff, dpos_m_ff;

   always_ff @(posedge clock) begin
      lhs_a_ff  <= dxa_ff * d_ff;
      lhs_b_ff  <= dxb_ff * d_ff;
      rhs_a_ff  <= dya_ff * ex_ff;
      rhs_b_ff  <= dyb_ff * ex_ff;
      cond_m_ff <= cond_d_ff;
      vert_m_ff <= vert_d_ff;
      dpos_m_ff <= dpos_d_ff;
   end

   // compare and toggle parity per corner
   logic signed [PROD_W-1:0] lhs [4];
   logic signed [PROD_W-1:0] rhs [4];
   logic [3:0]               toggle;
   logic [3:0]               odd_ff;

   assign lhs[0] = lhs_a_ff;
   assign lhs[1] = lhs_b_ff;
   assign lhs[2] = lhs_a_ff;
   assign lhs[3] = lhs_b_ff;
   assign rhs[0] = rhs_a_ff;
   assign rhs[1] = rhs_b_ff;
   assign rhs[2] = rhs_b_ff;
   assign rhs[3] = rhs_a_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         toggle[k] = cond_m_ff[k] &&
                     (vert_m_ff || (dpos_m_ff ? (lhs[k] <= rhs[k]) : (lhs[k] >= rhs[k])));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         odd_ff <= '0;
      end else if (m_v_ff) begin
         odd_ff <= odd_ff ^ toggle;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         rsp_hit <= zok_ff && (|odd_ff);
      end
   end

   assign status.zok   = zok_ff;
   assign status.empty = (count_sat == '0);
   assign status.last  = (CNT_W'(addr_ff) == (count_sat - CNT_W'(1)));
   assign status.busy  = rd_v_ff || close_ff || e_v_ff || d_v_ff || m_v_ff;
endmodule

>>> hw/rtl/box_vs_prism_overlap_top.sv
`timescale 1ns / 1ps
// Box versus vertical prism overlap. A request beat with func = write stores one polygon
// vertex and keeps the block ready; a beat with func = test checks a box and returns one
// hit beat. A test walks the polygon one edge per cycle, all four box corners in
// parallel, through a four-stage edge pipeline fed by the single read port of the vertex
// memory; no request is taken until its result is loaded, and the walk is skipped when
// the z spans miss or vertex_count, capped at MAX_VERTICES, is zero. Vertices must
// be written before a test reads them. Registers: 0 vertex_count, 1 base_z,
// 2 prism_height; write them only while no test is in flight.
module box_vs_prism_overlap_top #(
   parameter int MAX_VERTICES = bvpo_pkg::MAX_VERTICES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   bvpo_req_if.sink                         req_chan,
   bvpo_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [bvpo_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bvpo_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bvpo_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bvpo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   bvpo_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .vertex_index (req_chan.vertex_index),
      .vertex_x     (req_chan.vertex_x),
      .vertex_y     (req_chan.vertex_y),
      .box_min_x    (req_chan.box_min_x),
      .box_min_y    (req_chan.box_min_y),
      .box_min_z    (req_chan.box_min_z),
      .box_max_x    (req_chan.box_max_x),
      .box_max_y    (req_chan.box_max_y),
      .box_max_z    (req_chan.box_max_z),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_hit      (rsp_chan.hit)
   );
endmodule

>>> hw/rtl/bvpo_checker.sv
`timescale 1ns / 1ps
module bvpo_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_func,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit
);
   import bvpo_pkg::*;

   logic test_beat, write_beat;

   assign test_beat  = req_valid && req_ready && (req_func == FUNC_TEST);
   assign write_beat = req_valid && req_ready && (req_func == FUNC_WRITE);

   // a test occupies the block: no new request right after it
   a_test_blocks: assert property (@(posedge clock) disable iff (reset)
      test_beat |=> !req_ready)
      else $error("request taken in the cycle after a test beat");

   // a vertex write never stalls the request side
   a_write_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      write_beat |=> req_ready)
      else $error("ready dropped after a vertex write");

   // a result only appears after a test has held off requests
   a_rsp_from_test: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared with no test in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit)))
      else $error("stalled result beat changed");
endmodule

bind box_vs_prism_overlap_top bvpo_checker u_bvpo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_func  (req_chan.func),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hit   (rsp_chan.hit)
);
